@@ rtl/rbfk_pkg.sv @@
// shared constants for the squared exponential kernel entry block
`timescale 1ns / 1ps
package rbfk_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_DIMS   = 3'd0;
  localparam logic [2:0] CFG_LEN0   = 3'd1;
  localparam logic [2:0] CFG_JITTER = 3'd5;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned IN_LANES = 4;
  localparam int unsigned TDATA_IN_W = 2 * IN_LANES * COORD_W;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [24:0] EXP_CUTOFF = 25'(12 << 16);
  localparam int unsigned DIV_STEPS = 21;
  localparam int unsigned SQUARINGS = 12;
  // floor(v/6) for v < 256 as (v*171) >> 10
  localparam logic [7:0] RECIP6 = 8'd171;

endpackage

@@ rtl/rbf_kernel_entry.sv @@
// squared exponential ard kernel entry, fully pipelined
// throughput: one request per cycle unless backpressure stalls it; the long path is the 21-stage
// restoring divider, the twelve squaring multiplier stages and one product stage per dimension
// per-stage valid bits with local ready, so bubbles are squeezed out under backpressure
// reset (rst_ni low, async) empties the pipeline and restores the register defaults
`timescale 1ns / 1ps
module rbf_kernel_entry
  import rbfk_pkg::*;
#(
  parameter int MAX_DIMS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // point_a_0, point_a_1, point_a_2, point_a_3, point_b_0, point_b_1, point_b_2, point_b_3
  input  logic [TDATA_IN_W-1:0] s_axis_tdata_i,
  // add_diagonal
  input  logic [0:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // covariance
  output logic [31:0]           m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int L        = MAX_DIMS;
  localparam int ST_IN    = 0;
  localparam int ST_MAG   = 1;
  localparam int ST_DIV0  = 2;
  localparam int ST_X     = ST_DIV0 + DIV_STEPS;
  localparam int ST_G2    = ST_X + 1;
  localparam int ST_CUBE  = ST_G2 + 1;
  localparam int ST_E     = ST_CUBE + 1;
  localparam int ST_SQ0   = ST_E + 1;
  localparam int ST_F     = ST_SQ0 + SQUARINGS;
  localparam int ST_P0    = ST_F + 1;
  localparam int ST_OUT   = ST_P0 + L;
  localparam int NST      = ST_OUT + 1;

  // configuration registers
  logic [2:0]  dims_q;
  logic [31:0] len_q [L];
  logic [31:0] jit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 3'd4;
      for (int k = 0; k < L; k++) len_q[k] <= 32'(ONE_Q16);
      jit_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DIMS) dims_q <= cfg_data_i[2:0];
      if (cfg_index_i == CFG_JITTER) jit_q <= cfg_data_i;
      for (int k = 0; k < L; k++) begin
        if (cfg_index_i == CFG_LEN0 + 3'(k)) len_q[k] <= cfg_data_i;
      end
    end
  end

  // valid bits and local ready chain
  logic [NST-1:0] v_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = m_axis_tready_i;
    for (int k = NST - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // diagonal flag travels with the item
  logic [NST-1:0] dg_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) dg_q[0] <= s_axis_tuser_i[0];
    for (int k = 1; k < NST; k++) begin
      if (en[k]) dg_q[k] <= dg_q[k-1];
    end
  end

  // input stage
  logic [31:0] a_q [L];
  logic [31:0] b_q [L];

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      for (int k = 0; k < L; k++) begin
        a_q[k] <= s_axis_tdata_i[k*COORD_W +: COORD_W];
        b_q[k] <= s_axis_tdata_i[(IN_LANES + k)*COORD_W +: COORD_W];
      end
    end
  end

  // zero-factor and unit-factor flags per lane
  logic [L-1:0] fz_q [ST_MAG:ST_F-1];
  logic [L-1:0] fo_q [ST_MAG:ST_F-1];

  // divider state, index 0 is the magnitude stage
  logic [31:0] rem_q [DIV_STEPS+1][L];
  logic [20:0] quo_q [DIV_STEPS+1][L];
  logic [20:0] num_q [DIV_STEPS+1][L];

  // magnitude stage
  always_ff @(posedge clk_i) begin
    if (en[ST_MAG]) begin
      for (int k = 0; k < L; k++) begin
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic               on;
        diff = {a_q[k][31], a_q[k]} - {b_q[k][31], b_q[k]};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        on   = 3'(k) < dims_q;
        fo_q[ST_MAG][k] <= !on || (mag == '0);
        if (len_q[k] == '0) begin
          fz_q[ST_MAG][k] <= on && (mag != '0);
        end else begin
          fz_q[ST_MAG][k] <= on && ({4'b0, mag} >= {len_q[k], 5'b0});
        end
        rem_q[0][k] <= {4'b0, mag[32:5]};
        quo_q[0][k] <= '0;
        num_q[0][k] <= {mag[4:0], 16'b0};
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0+j]) begin
        for (int k = 0; k < L; k++) begin
          logic [32:0] t;
          logic        ge;
          t  = {rem_q[j][k], num_q[j][k][20]};
          ge = t >= {1'b0, len_q[k]};
          rem_q[j+1][k] <= ge ? 32'(t - {1'b0, len_q[k]}) : t[31:0];
          quo_q[j+1][k] <= {quo_q[j][k][19:0], ge};
          num_q[j+1][k] <= {num_q[j][k][19:0], 1'b0};
        end
      end
    end
  end

  // flag propagation, updated once x is known
  logic [24:0] x_q [L];

  for (genvar s = ST_MAG + 1; s < ST_F; s++) begin : g_flag
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        if (s == ST_X) begin
          for (int k = 0; k < L; k++) begin
            logic [41:0] sq;
            logic [24:0] x;
            sq = 42'(quo_q[DIV_STEPS][k]) * 42'(quo_q[DIV_STEPS][k]);
            x  = sq[41:17];
            // lanes already settled as unit factor ignore the quotient
            fz_q[s][k] <= fz_q[s-1][k] || (!fo_q[s-1][k] && (x >= EXP_CUTOFF));
            fo_q[s][k] <= fo_q[s-1][k] || (x == '0);
          end
        end else begin
          fz_q[s] <= fz_q[s-1];
          fo_q[s] <= fo_q[s-1];
        end
      end
    end
  end

  // x = r*r/2 in q9.16
  always_ff @(posedge clk_i) begin
    if (en[ST_X]) begin
      for (int k = 0; k < L; k++) begin
        logic [41:0] sq;
        sq = 42'(quo_q[DIV_STEPS][k]) * 42'(quo_q[DIV_STEPS][k]);
        x_q[k] <= sq[41:17];
      end
    end
  end

  // series for exp(-x/4096)
  logic [23:0] g_q  [L];
  logic [47:0] g2_q [L];
  logic [23:0] gc_q [L];
  logic [14:0] h_q  [L];
  logic [39:0] c_q  [L];
  logic [31:0] sq_q [SQUARINGS+1][L];

  always_ff @(posedge clk_i) begin
    if (en[ST_G2]) begin
      for (int k = 0; k < L; k++) begin
        logic [23:0] g;
        g = {x_q[k][19:0], 4'b0};
        g_q[k]  <= g;
        g2_q[k] <= 48'(g) * 48'(g);
      end
    end
    if (en[ST_CUBE]) begin
      for (int k = 0; k < L; k++) begin
        gc_q[k] <= g_q[k];
        h_q[k]  <= g2_q[k][47:33];
        c_q[k]  <= 40'(g2_q[k][47:32]) * 40'(g_q[k]);
      end
    end
    if (en[ST_E]) begin
      for (int k = 0; k < L; k++) begin
        logic [15:0] cm;
        logic [32:0] e;
        cm = 16'(c_q[k][39:32]) * 16'(RECIP6);
        e  = 33'h1_0000_0000 - 33'(gc_q[k]) + 33'(h_q[k]) - 33'(cm[15:10]);
        sq_q[0][k] <= e[31:0];
      end
    end
  end

  // twelve squarings, one multiplier per lane per stage
  for (genvar j = 0; j < SQUARINGS; j++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en[ST_SQ0+j]) begin
        for (int k = 0; k < L; k++) begin
          logic [63:0] pr;
          pr = 64'(sq_q[j][k]) * 64'(sq_q[j][k]);
          sq_q[j+1][k] <= pr[63:32];
        end
      end
    end
  end

  // per-lane factor, then carried along the product chain
  logic [16:0] fc_q [ST_F:ST_OUT-1][L];
  logic [16:0] p_q  [ST_P0:ST_OUT-1];

  always_ff @(posedge clk_i) begin
    if (en[ST_F]) begin
      for (int k = 0; k < L; k++) begin
        logic [32:0] rnd;
        rnd = 33'(sq_q[SQUARINGS][k]) + 33'h8000;
        priority if (fz_q[ST_F-1][k]) fc_q[ST_F][k] <= '0;
        else if (fo_q[ST_F-1][k]) fc_q[ST_F][k] <= ONE_Q16;
        else fc_q[ST_F][k] <= rnd[32:16];
      end
    end
  end

  for (genvar j = 0; j < L; j++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en[ST_P0+j]) begin
        logic [16:0] pin;
        logic [34:0] pr;
        pin = (j == 0) ? ONE_Q16 : p_q[ST_P0 + ((j == 0) ? 0 : j - 1)];
        pr  = 35'(pin) * 35'(fc_q[ST_P0+j-1][j]) + 35'h8000;
        p_q[ST_P0+j] <= pr[32:16];
        if (ST_P0 + j < ST_OUT - 1) fc_q[ST_P0 + ((ST_P0 + j < ST_OUT - 1) ? j : 0)] <=
          fc_q[ST_P0+j-1];
      end
    end
  end

  // jitter add with saturation
  logic [31:0] cov_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      logic [32:0] sum;
      sum = 33'(p_q[ST_OUT-1]) + (dg_q[ST_OUT-1] ? 33'(jit_q) : 33'd0);
      cov_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  assign m_axis_tvalid_o = v_q[ST_OUT];
  assign m_axis_tdata_o  = cov_q;

endmodule

@@ rtl/rbfk_checker.sv @@
// port-level checks for the kernel entry block and their bind
`timescale 1ns / 1ps
module rbfk_checker
  import rbfk_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [TDATA_IN_W-1:0] s_axis_tdata_i,
  input logic [0:0]            s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [31:0]           m_axis_tdata_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [2:0]            cfg_index_i,
  input logic [31:0]           cfg_data_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // input backpressure only when the pipeline is full and the output is blocked
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result offered during reset");

endmodule

bind rbf_kernel_entry rbfk_checker u_rbfk_checker (.*);

@@ tb/sv/tb_rbf_kernel_entry.sv @@
// self-checking testbench for the squared exponential kernel entry block
`timescale 1ns / 1ps
module tb_rbf_kernel_entry;
  import rbfk_pkg::*;

  localparam int LATENCY = 44;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [TDATA_IN_W-1:0] coords;
    logic                  diag;
  } pair_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [TDATA_IN_W-1:0] s_axis_tdata_i;
  logic [0:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [31:0]           m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i;
  logic [31:0]           cfg_data_i;

  rbf_kernel_entry DUT (.*);

  // testbench copy of the block registers
  logic [2:0]  dims_q;
  logic [31:0] len_q [4];
  logic [31:0] jitter_q;

  pair_t       pending_pairs[$];
  logic [31:0] expected_cov[$];
  int          errors, checked, sent, cycles;
  int          send_gap, recv_gap;
  bit          quiet, pair_taken;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] exp_neg_q16(logic [63:0] x);
    logic [63:0] g, g2, cube, e;
    g = x * 16;
    g2 = g * g;
    cube = (((g2 >> 32) * g) >> 32) / 6;
    e = (64'd1 << 32) - g + (g2 >> 33) - cube;
    for (int i = 0; i < 12; i++) e = (e * e) >> 32;
    return 32'((e + 64'h8000) >> 16);
  endfunction

  function automatic logic [31:0] dim_factor(logic [31:0] a, logic [31:0] b, logic [31:0] len);
    logic signed [63:0] d;
    logic [63:0] mag, r, x;
    d = 64'(signed'(a)) - 64'(signed'(b));
    mag = d < 0 ? -d : d;
    if (len == 0) return mag == 0 ? 32'h10000 : 32'h0;
    r = (mag << 16) / len;
    if (r >= (64'd1 << 21)) return 32'h0;
    x = (r * r) >> 17;
    if (x >= 64'(12 << 16)) return 32'h0;
    if (x == 0) return 32'h10000;
    return exp_neg_q16(x);
  endfunction

  function automatic logic [31:0] covariance_of(pair_t p);
    logic [63:0] prod;
    int n;
    prod = 64'h10000;
    n = dims_q > 4 ? 4 : dims_q;
    for (int k = 0; k < n; k++)
      prod = (prod * dim_factor(p.coords[32*k +: 32], p.coords[32*(4+k) +: 32], len_q[k])
              + 64'h8000) >> 16;
    if (p.diag) prod += jitter_q;
    return prod > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  // input side: accepted requests get their expected covariance
  always @(posedge clk_i) begin
    pair_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && pair_taken) begin
      expected_cov.push_back(covariance_of('{s_axis_tdata_i, s_axis_tuser_i[0]}));
      sent++;
    end
  end

  // output side monitor
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_cov.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_axis_tdata_o);
      end else begin
        logic [31:0] want;
        want = expected_cov.pop_front();
        checked++;
        if (want !== m_axis_tdata_o) begin
          errors++;
          if (errors <= 10)
            $display("covariance mismatch: expected %h got %h", want, m_axis_tdata_o);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || pair_taken)) begin
      if (send_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
        send_gap = $urandom_range(1, 16);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        pair_t p;
        p = pending_pairs.pop_front();
        s_axis_tdata_i <= p.coords;
        s_axis_tuser_i <= p.diag;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (recv_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
      recv_gap = $urandom_range(1, 16);
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_DIMS) dims_q = val[2:0];
    else if (idx == CFG_JITTER) jitter_q = val;
    else len_q[idx - CFG_LEN0] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !s_axis_tvalid_i && expected_cov.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic add_pair(logic [31:0] a, logic [31:0] b, logic diag);
    pair_t p;
    for (int k = 0; k < 4; k++) begin
      p.coords[32*k +: 32] = a;
      p.coords[32*(4+k) +: 32] = b;
    end
    p.diag = diag;
    pending_pairs.push_back(p);
  endtask

  // mostly pairs whose distance is comparable to the length scale
  task automatic add_random_pair();
    pair_t p;
    logic [63:0] delta;
    logic [31:0] b;
    for (int k = 0; k < 4; k++) begin
      b = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        p.coords[32*k +: 32] = $urandom;
      end else begin
        delta = (64'(len_q[k]) * $urandom_range(0, 5000)) >> 10;
        if ($urandom_range(0, 3) == 0) delta = $urandom_range(0, 3);
        if (delta > 64'h7FFF_FFFF) delta = $urandom;
        p.coords[32*k +: 32] = $urandom_range(0, 1) ? b + delta[31:0] : b - delta[31:0];
      end
      p.coords[32*(4+k) +: 32] = b;
    end
    p.diag = $urandom_range(0, 1);
    pending_pairs.push_back(p);
  endtask

  initial begin
    logic [31:0] lens [4];
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DIMS;
    cfg_data_i = '0;
    dims_q = 3'd4;
    for (int k = 0; k < 4; k++) len_q[k] = 32'h10000;
    jitter_q = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset defaults, coordinate extremes, equal points
    add_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_pair(32'h0, 32'h0, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_pair(32'h0001_0000, 32'h0, 1'b0);
    add_pair(32'h0, 32'h0000_0001, 1'b0);
    add_pair(32'h0003_0000, 32'h0, 1'b1);
    add_pair(32'h0004_E000, 32'h0, 1'b0);
    add_pair(32'h0000_0100, 32'h0, 1'b0);
    drain();
    // zero length scale, saturating jitter, dims zero and above the maximum
    write_reg(CFG_JITTER, 32'hFFFF_FFFF);
    write_reg(CFG_LEN0, 32'h0);
    add_pair(32'h0, 32'h0, 1'b1);
    add_pair(32'h1, 32'h0, 1'b1);
    add_pair(32'h1, 32'h0, 1'b0);
    drain();
    write_reg(CFG_DIMS, 3'd0);
    add_pair(32'h1234_5678, 32'h8765_4321, 1'b0);
    add_pair(32'h1234_5678, 32'h8765_4321, 1'b1);
    drain();
    write_reg(CFG_DIMS, 3'd7);
    write_reg(CFG_LEN0 + 3'd3, 32'hFFFF_FFFF);
    add_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_pair(32'h0, 32'h0, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 4; k++)
        case ($urandom_range(0, 5))
          0: lens[k] = 32'h1;
          1: lens[k] = 32'hFFFF_FFFF;
          2: lens[k] = 32'h0;
          3: lens[k] = $urandom;
          default: lens[k] = $urandom_range(32'h100, 32'h40_0000);
        endcase
      write_reg(CFG_DIMS, ph == 0 ? 3'd1 : $urandom_range(0, 7));
      for (int k = 0; k < 4; k++) write_reg(CFG_LEN0 + 3'(k), lens[k]);
      write_reg(CFG_JITTER, ph == 1 ? 32'hFFFF_FFFF : (ph == 2 ? 32'h0 : $urandom));
      quiet = (ph == 7);
      for (int i = 0; i < 220; i++) add_random_pair();
      drain();
    end

    $display("checked %0d covariance results from %0d requests", checked, sent);
    $display("register settings swept: dims 0..7, zero/min/max length scales, jitter extremes");
    if (errors == 0 && expected_cov.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ rbf_kernel_entry.f @@
rtl/rbfk_pkg.sv
rtl/rbf_kernel_entry.sv
rtl/rbfk_checker.sv
tb/sv/tb_rbf_kernel_entry.sv
